/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared constants, opcodes, status codes and shared-unit operations.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned ARENA_WORDS_DEF = 1024;

  // header word and intermediate widths
  localparam int unsigned HDR_W  = 12;
  localparam int unsigned NEED_W = 13;

  // largest block size a header can hold
  localparam int unsigned HDR_MAX_SIZE = 4092;
  // bytes added to a rounded request or heap size
  localparam int unsigned BLK_PAD      = 20;

  localparam logic [HDR_W-1:0] HEAP_SIZE_RST = 12'd4072;
  localparam logic [HDR_W-1:0] SIZE_MASK     = 12'hFFC;
  localparam logic [HDR_W-1:0] ALIGN8_MASK   = 12'hFF8;
  localparam logic [HDR_W-1:0] ALLOC_FLAG    = 12'h001;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_COALESCE = 2'd2
  } opcode_e;

  typedef enum logic {
    ST_OK     = 1'b0,
    ST_NO_FIT = 1'b1
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

endpackage

/* hw/rtl/ffba_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ffba_alu.sv */
// ----------------------------------------------------------------------------
// Allocator shared arithmetic unit
// One adder/subtractor; carry out doubles as the a >= b compare.
// ----------------------------------------------------------------------------
module ffba_alu #(
  parameter int unsigned WIDTH = 13
) (
  input  ffba_pkg::alu_op_e op_i,
  input  logic [WIDTH-1:0]  a_i,
  input  logic [WIDTH-1:0]  b_i,
  output logic [WIDTH-1:0]  sum_o,
  output logic              carry_o
);
  import ffba_pkg::*;

  logic [WIDTH-1:0] b_eff;
  logic             cin;
  logic [WIDTH:0]   full;

  assign cin   = (op_i == ALU_SUB);
  assign b_eff = cin ? ~b_i : b_i;
  assign full  = {1'b0, a_i} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};

  assign sum_o   = full[WIDTH-1:0];
  assign carry_o = full[WIDTH];

endmodule

/* hw/rtl/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator
// Implicit block list over a header RAM, walked by a sequencer that drives
// one shared adder/subtractor. Allocate, free and coalesce operations.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload                                Dir
//  --------  -------------------  -------------------------------------  ---
//  in        in_valid/in_ready    opcode, request_length, payload_offset  in
//  out       out_valid/out_ready  status, granted_offset                  out
//  cfg       cfg_valid/cfg_ready  heap_size                               in
//
//  Unused opcodes and zero-length allocates go straight to the response; free
//  clears one header's flag; allocate reads, checks and advances per block
//  skipped, then marks, splits if needed and grants; coalesce merges neighbors.
//  Reset and each heap_size transaction clear all ARENA_WORDS words first
//  (in_ready, cfg_ready low). One operation at a time; a result waits in the
//  output register while out_ready is low; the next result then waits in S_RESP.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
  parameter int unsigned ARENA_WORDS = ffba_pkg::ARENA_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // operation channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [ffba_pkg::HDR_W-1:0] request_length_i,
  input  logic [ffba_pkg::HDR_W-1:0] payload_offset_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       status_o,
  output logic [ffba_pkg::HDR_W-1:0] granted_offset_o,
  // heap size register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ffba_pkg::HDR_W-1:0] heap_size_i
);
  import ffba_pkg::*;

  // RAM address, walk pointer and block counter widths.
  // A header stride is at most 2**(HDR_W-2) words past an in-arena index.
  localparam int unsigned AW         = $clog2(ARENA_WORDS);
  localparam int unsigned MAX_STRIDE = 2 ** (HDR_W - 2);
  localparam int unsigned PW         = $clog2(ARENA_WORDS + MAX_STRIDE);
  localparam int unsigned CW         = $clog2(ARENA_WORDS + 1);
  localparam int unsigned ALU_W      = (PW > NEED_W) ? PW : NEED_W;
  // largest formatted block: room for the end header and fits a header
  localparam int unsigned CAP_RAW    = (ARENA_WORDS - 1) * 4;
  localparam int unsigned CAP        = (CAP_RAW > HDR_MAX_SIZE) ? HDR_MAX_SIZE : CAP_RAW;

  typedef enum logic [17:0] {
    S_CLEAR   = 18'h00001,
    S_IDLE    = 18'h00002,
    S_A_NEED  = 18'h00004,
    S_A_RD    = 18'h00008,
    S_A_CHK   = 18'h00010,
    S_A_ADV   = 18'h00020,
    S_A_TAKE  = 18'h00040,
    S_A_SPLIT = 18'h00080,
    S_A_GRANT = 18'h00100,
    S_F_IDX   = 18'h00200,
    S_F_RD    = 18'h00400,
    S_F_WR    = 18'h00800,
    S_C_RD_I  = 18'h01000,
    S_C_CHK_I = 18'h02000,
    S_C_RD_J  = 18'h04000,
    S_C_CHK_J = 18'h08000,
    S_C_ADV_J = 18'h10000,
    S_RESP    = 18'h20000
  } state_e;

  // control state
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [HDR_W-1:0]  heap_q, heap_d;
  logic              out_valid_q, out_valid_d;

  // operation working registers
  logic [HDR_W-1:0]  len_q, len_d;
  logic [HDR_W-1:0]  off_q, off_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [PW-1:0]     idx_q, idx_d;     // block under test (alloc) / run head (coalesce)
  logic [PW-1:0]     j_q, j_d;         // split point, free target, or next neighbor
  logic [CW-1:0]     n_q, n_d;         // blocks visited
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic [HDR_W-1:0]  diff_q, diff_d;
  logic [HDR_W-1:0]  sj_q, sj_d;
  logic              res_status_q, res_status_d;
  logic [HDR_W-1:0]  res_grant_q, res_grant_d;
  logic              out_status_q, out_status_d;
  logic [HDR_W-1:0]  out_grant_q, out_grant_d;

  // shared unit
  alu_op_e           alu_op;
  logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_carry;

  // header RAM
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [HDR_W-1:0]  ram_wdata, ram_rdata;

  // decoded views
  logic [HDR_W-1:0]  rd_size, hdr_size, total;
  logic              idx_in, j_in, n_in;

  ffba_alu #(
    .WIDTH (ALU_W)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  ffba_ram #(
    .WIDTH (HDR_W),
    .DEPTH (ARENA_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_size  = ram_rdata & SIZE_MASK;
  assign hdr_size = hdr_q & SIZE_MASK;
  assign idx_in   = idx_q < PW'(ARENA_WORDS);
  assign j_in     = j_q < PW'(ARENA_WORDS);
  assign n_in     = n_q < CW'(ARENA_WORDS);

  // formatted block size, clamped; the adder produces the rounded sum in S_CLEAR
  assign total = (alu_sum > ALU_W'(CAP)) ? HDR_W'(CAP) : alu_sum[HDR_W-1:0];

  // Accept a new operation only when idle; a heap_size write wins a tie.
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    heap_d       = heap_q;
    len_d        = len_q;
    off_d        = off_q;
    need_d       = need_q;
    idx_d        = idx_q;
    j_d          = j_q;
    n_d          = n_q;
    hdr_d        = hdr_q;
    diff_d       = diff_q;
    sj_d         = sj_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    // drop the held result once it is taken
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_grant_d  = out_grant_q;

    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_raddr = idx_q[AW-1:0];
    ram_wdata = '0;

    case (state_q)
      // Sweep the whole RAM: free block header at word 0, zero elsewhere.
      S_CLEAR: begin
        alu_a     = ALU_W'(heap_q & ALIGN8_MASK);
        alu_b     = ALU_W'(BLK_PAD);
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? total : '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(ARENA_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cfg_valid_i) begin
          heap_d  = heap_size_i;
          clr_d   = '0;
          state_d = S_CLEAR;
        end else if (in_valid_i) begin
          len_d        = request_length_i;
          off_d        = payload_offset_i;
          idx_d        = '0;
          n_d          = '0;
          res_status_d = ST_OK;
          res_grant_d  = '0;
          case (opcode_i)
            OP_ALLOC: begin
              // assume no fit until a block is granted
              res_status_d = ST_NO_FIT;
              state_d      = (request_length_i == '0) ? S_RESP : S_A_NEED;
            end
            OP_FREE:     state_d = S_F_IDX;
            OP_COALESCE: state_d = S_C_RD_I;
            default:     state_d = S_RESP;
          endcase
        end
      end

      S_A_NEED: begin
        alu_a   = ALU_W'(len_q & ALIGN8_MASK);
        alu_b   = ALU_W'(BLK_PAD);
        need_d  = alu_sum[NEED_W-1:0];
        state_d = S_A_RD;
      end

      S_A_RD: begin
        if (n_in && idx_in) begin
          ram_re  = 1'b1;
          state_d = S_A_CHK;
        end else begin
          state_d = S_RESP;
        end
      end

      // size - need: carry out means the block is large enough
      S_A_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(rd_size);
        alu_b  = ALU_W'(need_q);
        hdr_d  = ram_rdata;
        diff_d = alu_sum[HDR_W-1:0];
        if ((ram_rdata == '0) || (rd_size == '0)) begin
          state_d = S_RESP;
        end else if (!ram_rdata[0] && alu_carry) begin
          state_d = S_A_TAKE;
        end else begin
          state_d = S_A_ADV;
        end
      end

      S_A_ADV: begin
        alu_a   = ALU_W'(idx_q);
        alu_b   = ALU_W'(hdr_size >> 2);
        idx_d   = alu_sum[PW-1:0];
        n_d     = n_q + 1'b1;
        state_d = S_A_RD;
      end

      // mark the block taken; compute where the remainder header goes
      S_A_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ((diff_q == '0) ? hdr_size : need_q[HDR_W-1:0]) | ALLOC_FLAG;
        alu_a     = ALU_W'(idx_q);
        alu_b     = ALU_W'(need_q >> 2);
        j_d       = alu_sum[PW-1:0];
        state_d   = (diff_q == '0) ? S_A_GRANT : S_A_SPLIT;
      end

      S_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = diff_q;
        state_d   = S_A_GRANT;
      end

      // payload offset = (idx + 1) * 4
      S_A_GRANT: begin
        alu_a        = ALU_W'(idx_q);
        alu_b        = ALU_W'(1);
        res_grant_d  = {alu_sum[HDR_W-3:0], 2'b00};
        res_status_d = ST_OK;
        state_d      = S_RESP;
      end

      // header index = offset / 4 - 1; drop offsets off the header grid
      S_F_IDX: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(off_q >> 2);
        alu_b  = ALU_W'(1);
        j_d    = alu_sum[PW-1:0];
        if ((off_q[HDR_W-1:2] != '0) && (off_q[1:0] == 2'b00) &&
            (alu_sum < ALU_W'(ARENA_WORDS))) begin
          state_d = S_F_RD;
        end else begin
          state_d = S_RESP;
        end
      end

      S_F_RD: begin
        ram_re    = 1'b1;
        ram_raddr = j_q[AW-1:0];
        state_d   = S_F_WR;
      end

      S_F_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = ram_rdata & ~ALLOC_FLAG;
        state_d   = S_RESP;
      end

      S_C_RD_I: begin
        if (n_in && idx_in) begin
          ram_re  = 1'b1;
          state_d = S_C_CHK_I;
        end else begin
          state_d = S_RESP;
        end
      end

      S_C_CHK_I: begin
        alu_a = ALU_W'(idx_q);
        alu_b = ALU_W'(rd_size >> 2);
        if ((ram_rdata == '0) || (rd_size == '0)) begin
          state_d = S_RESP;
        end else begin
          hdr_d   = ram_rdata;
          j_d     = alu_sum[PW-1:0];
          n_d     = n_q + 1'b1;
          state_d = S_C_RD_J;
        end
      end

      // keep merging while the run head is free and the neighbor is in range
      S_C_RD_J: begin
        if (n_in && !hdr_q[0] && j_in) begin
          ram_re    = 1'b1;
          ram_raddr = j_q[AW-1:0];
          state_d   = S_C_CHK_J;
        end else begin
          idx_d   = j_q;
          state_d = S_C_RD_I;
        end
      end

      S_C_CHK_J: begin
        alu_a = ALU_W'(hdr_q);
        alu_b = ALU_W'(rd_size);
        if ((ram_rdata != '0) && !ram_rdata[0] && (rd_size != '0)) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = alu_sum[HDR_W-1:0];
          hdr_d     = alu_sum[HDR_W-1:0];
          sj_d      = rd_size;
          state_d   = S_C_ADV_J;
        end else begin
          idx_d   = j_q;
          state_d = S_C_RD_I;
        end
      end

      S_C_ADV_J: begin
        alu_a   = ALU_W'(j_q);
        alu_b   = ALU_W'(sj_q >> 2);
        j_d     = alu_sum[PW-1:0];
        n_d     = n_q + 1'b1;
        state_d = S_C_RD_J;
      end

      // hold until the output register is free
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_grant_d  = res_grant_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      heap_q      <= HEAP_SIZE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      heap_q      <= heap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    off_q        <= off_d;
    need_q       <= need_d;
    idx_q        <= idx_d;
    j_q          <= j_d;
    n_q          <= n_d;
    hdr_q        <= hdr_d;
    diff_q       <= diff_d;
    sj_q         <= sj_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_grant_q;

  // a heap_size write restarts the clearing pass from word 0
  a_cfg_reformats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> (state_q == S_CLEAR) && (clr_q == '0))
    else $error("heap_size write did not start a clearing pass");

  // a failed allocation never reports an offset
  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_NO_FIT) |-> (out_grant_q == '0))
    else $error("no-fit result carries a nonzero offset");

  // results enter the output register only from the response state
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result loaded outside the response state");

  // walks stop at the block bound
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_RD) || (state_q == S_C_RD_I) || (state_q == S_C_RD_J)
    |-> (n_q <= CW'(ARENA_WORDS)))
    else $error("block counter passed the walk bound");

  // a split header lands inside the arena
  a_split_in_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SPLIT) |-> j_in)
    else $error("split header outside the arena");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives allocate, free, coalesce and unused operations plus heap_size
// rewrites into the allocator. A cycle-free copy of the header list tracks
// every transaction and predicts each result. A checker compares status and
// offset of every result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import ffba_pkg::*;

  typedef logic [HDR_W-1:0] hdr_t;

  typedef struct packed {
    status_e st;
    hdr_t    goff;
  } grant_t;

  localparam int unsigned WORDS     = ARENA_WORDS_DEF;
  // opcode 3 has no operation behind it; it must still return a plain ok
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  // longest stretch without any accepted transaction before giving up
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASE_OPS   = 186;

  logic clk_i            = 1'b0;
  logic rst_ni           = 1'b0;
  logic in_valid_i       = 1'b0;
  logic [1:0] opcode_i   = '0;
  hdr_t request_length_i = '0;
  hdr_t payload_offset_i = '0;
  logic out_ready_i      = 1'b0;
  logic cfg_valid_i      = 1'b0;
  hdr_t heap_size_i      = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic status_o;
  hdr_t granted_offset_o;
  logic cfg_ready_o;

  // header list as the allocator should hold it
  hdr_t hdr_mem [WORDS];
  // results still owed by the allocator, oldest first
  grant_t pending_q[$];
  // payload offsets currently handed out, candidates for free
  hdr_t held_q[$];

  int in_gap_max  = 16;
  int out_gap_max = 16;
  int unsigned bad_count;
  int unsigned n_ops, n_results, n_granted, n_no_fit, n_free, n_merge, n_cfg;
  int unsigned quiet_cycles;

  always #5 clk_i = ~clk_i;

  first_fit_block_allocator_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .request_length_i (request_length_i),
    .payload_offset_i (payload_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .heap_size_i      (heap_size_i)
  );

  // --------------------------------------------------------------------------
  // Header list tracking
  // --------------------------------------------------------------------------

  function automatic bit hdr_live(int unsigned idx);
    return idx < WORDS && hdr_mem[idx] != '0;
  endfunction

  // Lay out one free block followed by the end header; clamp the block so
  // the end header still fits and the size fits a header word.
  function automatic void arena_format(hdr_t size);
    int unsigned cap, total;
    cap = (WORDS - 1) * 4;
    if (cap > HDR_MAX_SIZE) cap = HDR_MAX_SIZE;
    total = size & ALIGN8_MASK;
    total += BLK_PAD;
    if (total > cap) total = cap;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    hdr_mem[0] = hdr_t'(total);
    hdr_mem[total / 4] = '0;
  endfunction

  // Walk first fit; split a larger free block and leave its tail free.
  function automatic void arena_alloc(hdr_t len, output status_e st, output hdr_t goff);
    int unsigned need, idx, n, sz;
    st   = ST_NO_FIT;
    goff = '0;
    if (len == '0) return;
    need = len & ALIGN8_MASK;
    need += BLK_PAD;
    idx  = 0;
    for (n = 0; n < WORDS && hdr_live(idx); n++) begin
      sz = hdr_mem[idx] & SIZE_MASK;
      if (sz == 0) break;
      if (!hdr_mem[idx][0] && sz >= need) begin
        if (sz > need) begin
          hdr_mem[idx] = hdr_t'(need);
          hdr_mem[idx + need / 4] = hdr_t'(sz - need);
        end
        hdr_mem[idx] = hdr_mem[idx] | ALLOC_FLAG;
        st   = ST_OK;
        goff = hdr_t'(idx * 4 + 4);
        return;
      end
      idx += sz / 4;
    end
  endfunction

  // Clear the flag 4 bytes below the payload; drop misaligned offsets.
  function automatic void arena_free(hdr_t off);
    int unsigned idx;
    if (off < 4 || off[1:0] != 2'b00) return;
    idx = (off - 4) / 4;
    if (idx >= WORDS) return;
    hdr_mem[idx] = hdr_mem[idx] & ~ALLOC_FLAG;
  endfunction

  // Fold every run of free neighbors into its first block.
  function automatic void arena_merge_free();
    int unsigned i, j, n, sz, sj;
    i = 0;
    n = 0;
    while (n < WORDS && hdr_live(i)) begin
      sz = hdr_mem[i] & SIZE_MASK;
      if (sz == 0) break;
      j = i + sz / 4;
      n++;
      while (n < WORDS && !hdr_mem[i][0] && hdr_live(j) && !hdr_mem[j][0]) begin
        sj = hdr_mem[j] & SIZE_MASK;
        if (sj == 0) break;
        hdr_mem[i] = hdr_t'(hdr_mem[i] + sj);
        j += sj / 4;
        n++;
      end
      i = j;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Operation channel
  // --------------------------------------------------------------------------

  // Send one operation after a random gap, then update the tracked list and
  // queue the result it owes. Valid stays high after the transaction so a
  // back-to-back operation never drops it for a step.
  task automatic issue_op(logic [1:0] op, hdr_t len, hdr_t off);
    int unsigned gap;
    grant_t res;
    gap = $urandom_range(in_gap_max, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    request_length_i <= len;
    payload_offset_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    res.st   = ST_OK;
    res.goff = '0;
    case (op)
      OP_ALLOC: begin
        arena_alloc(len, res.st, res.goff);
        if (res.st == ST_OK) begin
          held_q.push_back(res.goff);
          n_granted++;
        end else begin
          n_no_fit++;
        end
      end
      OP_FREE: begin
        arena_free(off);
        n_free++;
      end
      OP_COALESCE: begin
        arena_merge_free();
        n_merge++;
      end
      default: ;
    endcase
    pending_q.push_back(res);
    n_ops++;
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Rewrite heap_size while idle; the allocator reformats the arena.
  task automatic write_heap_size(hdr_t size);
    settle();
    cfg_valid_i <= 1'b1;
    heap_size_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    arena_format(size);
    held_q.delete();
    n_cfg++;
  endtask

  // --------------------------------------------------------------------------
  // Result channel: random stall before each transaction
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    forever begin
      stall = $urandom_range(out_gap_max, 0);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every result with the oldest owed one.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected result status %0d offset %0d",
                   $time, status_o, granted_offset_o);
      end else begin
        want = pending_q.pop_front();
        if (status_o !== want.st || granted_offset_o !== want.goff) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                     $time, want.st, want.goff, status_o, granted_offset_o);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero length, the smallest sizes, a split, a request beyond any block.
  task automatic test_alloc_paths();
    issue_op(OP_ALLOC, hdr_t'(0), '1);
    issue_op(OP_ALLOC, hdr_t'(1), '0);
    issue_op(OP_ALLOC, hdr_t'(7), '0);
    issue_op(OP_ALLOC, hdr_t'(8), '0);
    issue_op(OP_ALLOC, '1, '0);
    // leaves a 4-byte tail block behind the split
    issue_op(OP_ALLOC, hdr_t'(4000), '0);
  endtask

  // Double free, offsets off the header grid, exact fit into a freed block,
  // coalesce of neighbors and the unused opcode.
  task automatic test_free_paths();
    issue_op(OP_FREE, '1, hdr_t'(4));
    issue_op(OP_FREE, '0, hdr_t'(4));
    issue_op(OP_FREE, '0, hdr_t'(0));
    issue_op(OP_FREE, '0, hdr_t'(6));
    issue_op(OP_FREE, '0, '1);
    issue_op(OP_FREE, '0, hdr_t'(4092));
    issue_op(OP_ALLOC, hdr_t'(1), '0);
    issue_op(OP_FREE, '0, hdr_t'(24));
    issue_op(OP_FREE, '0, hdr_t'(44));
    issue_op(OP_COALESCE, '1, '1);
    issue_op(OP_UNUSED, '1, '1);
  endtask

  // Smallest arena and the clamped largest arena.
  task automatic test_heap_extremes();
    write_heap_size('0);
    issue_op(OP_ALLOC, hdr_t'(1), '0);
    issue_op(OP_ALLOC, hdr_t'(1), '0);
    issue_op(OP_FREE, '0, hdr_t'(4));
    issue_op(OP_COALESCE, '0, '0);
    write_heap_size('1);
    issue_op(OP_ALLOC, hdr_t'(4072), '0);
    issue_op(OP_FREE, '0, hdr_t'(4));
  endtask

  // Mostly well-formed traffic: allocate small blocks, free what was
  // granted, coalesce now and then; mix in wild offsets, double frees and
  // huge or zero lengths. Each phase uses its own heap size and idling.
  task automatic test_random_traffic();
    hdr_t heaps [5];
    int   in_max [5];
    int   out_max [5];
    int unsigned r, pick;
    hdr_t len, off;
    heaps   = '{hdr_t'(4072), hdr_t'($urandom_range(4095, 0)), '1, hdr_t'(64),
                hdr_t'($urandom_range(1023, 0))};
    in_max  = '{16, 0, 16, 0, 16};
    out_max = '{16, 0, 0, 16, 16};
    for (int p = 0; p < 5; p++) begin
      write_heap_size(heaps[p]);
      in_gap_max  = in_max[p];
      out_gap_max = out_max[p];
      for (int k = 0; k < PHASE_OPS; k++) begin
        r = $urandom_range(99, 0);
        if (r < 45) begin
          r = $urandom_range(9, 0);
          if (r < 8) len = hdr_t'($urandom_range(200, 1));
          else if (r < 9) len = hdr_t'($urandom_range(4095, 0));
          else len = hdr_t'($urandom_range(7, 0));
          issue_op(OP_ALLOC, len, hdr_t'($urandom_range(4095, 0)));
        end else if (r < 80) begin
          if (held_q.size() != 0 && $urandom_range(9, 0) != 0) begin
            pick = $urandom_range(held_q.size() - 1, 0);
            off  = held_q[pick];
            // keep some entries so they get freed a second time
            if ($urandom_range(7, 0) != 0) held_q.delete(pick);
          end else begin
            off = hdr_t'($urandom_range(4095, 0));
            if ($urandom_range(1, 0) != 0) off[1:0] = 2'b00;
          end
          issue_op(OP_FREE, hdr_t'($urandom_range(4095, 0)), off);
        end else if (r < 95) begin
          issue_op(OP_COALESCE, hdr_t'($urandom_range(4095, 0)),
                   hdr_t'($urandom_range(4095, 0)));
        end else begin
          issue_op(OP_UNUSED, hdr_t'($urandom_range(4095, 0)),
                   hdr_t'($urandom_range(4095, 0)));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    arena_format(HEAP_SIZE_RST);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_alloc_paths();
    test_free_paths();
    test_heap_extremes();
    test_random_traffic();

    // drain, then give a late stray result time to show up
    settle();
    repeat (64) @(posedge clk_i);

    $display("Ran %0d operations (%0d grants, %0d no-fit, %0d frees, %0d coalesces)",
             n_ops, n_granted, n_no_fit, n_free, n_merge);
    $display("over %0d heap_size rewrites; %0d results checked, %0d bad",
             n_cfg, n_results, bad_count);
    if (bad_count == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/ffba_alu.sv
hw/rtl/first_fit_block_allocator_unit.sv
dv/tb.sv
